@@ rtl/elme_pkg.sv @@
// Package for the event list minimum extract unit.
// Holds the entry type, the op and status codes and the default store depth.
// No dependencies.
package elme_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int KIND_W = 4;
	localparam int TIME_W = 32;
	localparam int LIVE_W = 7;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] duration;
		logic [TIME_W-1:0] start;
		logic [KIND_W-1:0] kind;
	} entry_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

@@ rtl/elme_store.sv @@
// Event store: one write port and one registered read port.
// Depends on elme_pkg for the entry type.
module elme_store
	import elme_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/elme_scan.sv @@
// Shared compare unit: keeps the earliest-start entry seen during a scan
// and the entry read from the last live slot. Depends on elme_pkg.
module elme_scan
	import elme_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  scan_ctl_t     ctl,
	input  logic [AW-1:0] idx,
	input  entry_t        data,
	output entry_t        best,
	output logic [AW-1:0] best_idx,
	output entry_t        last_ent
);

	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	entry_t        last_q;
	logic          take;

	// Strictly less keeps the lowest slot on equal start times.
	assign take = ctl.vld && (ctl.first || (data.start < best_q.start));

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= data;
			best_idx_q <= idx;
		end
		if (ctl.vld && ctl.last) begin
			last_q <= data;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;
	assign last_ent = last_q;

endmodule

@@ rtl/event_list_min_extract_unit.sv @@
// Insert, and extract on an empty store: the result is registered in the cycle after the item is accepted.
// Extract on n live events: the live slots are read, one store read per cycle through the single
// read port feeding one 32-bit comparator, then one write that moves the last event.
// One item is handled at a time; a new item is taken when the sequencer is idle and the
// result register is free or being emptied. arst_n clears the count, sequencer and
// output valid; store contents are undefined until written.
module event_list_min_extract_unit
	import elme_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // event_kind[3:0], start_time[35:4], duration[67:36]
	input  logic        s_tuser,  // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // out_kind[3:0], out_start[35:4], out_duration[67:36],
	                              // live_count[74:68], is_empty[75]
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] issue_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          m_tvalid_q;
	logic [79:0]   m_tdata_q;
	logic [1:0]    m_tuser_q;

	logic          s_acc;
	logic          in_op;
	entry_t        in_ent;
	logic          not_full;
	logic [CW-1:0] cnt_dec;
	logic          issue;
	logic          set_vld;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	entry_t        rdata;
	scan_ctl_t     ctl;
	entry_t        best;
	logic [AW-1:0] best_idx;
	entry_t        last_ent;

	assign in_op        = s_tuser;
	assign in_ent.kind  = s_tdata[3:0];
	assign in_ent.start = s_tdata[35:4];
	assign in_ent.duration = s_tdata[67:36];

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;
	assign not_full = cnt_q < CW'(DEPTH);
	assign cnt_dec  = cnt_q - CW'(1);
	assign issue    = (state_q == S_SCAN) && (issue_q < cnt_q);

	// A result is loaded by an insert, by an extract on an empty store, or at the end of a scan.
	assign set_vld  = (state_q == S_FIN) ||
		(s_acc && ((in_op == OP_INSERT) || (cnt_q == '0)));

	// Writes come from an accepted insert, or from moving the last event into the freed slot.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = in_ent;
		if (state_q == S_FIN) begin
			we    = 1'b1;
			waddr = best_idx;
			wdata = last_ent;
		end else if (s_acc && (in_op == OP_INSERT) && not_full) begin
			we = 1'b1;
		end
	end

	elme_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (issue_q[AW-1:0]),
		.rdata (rdata)
	);

	assign ctl.vld   = rd_vld_s1;
	assign ctl.first = (rd_idx_s1 == '0);
	assign ctl.last  = (rd_idx_s1 == cnt_dec[AW-1:0]);

	elme_scan #(.DEPTH(DEPTH), .AW(AW)) u_scan (
		.clk      (clk),
		.ctl      (ctl),
		.idx      (rd_idx_s1),
		.data     (rdata),
		.best     (best),
		.best_idx (best_idx),
		.last_ent (last_ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			issue_q    <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				issue_q <= issue_q + CW'(1);
			end
			if (set_vld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (in_op == OP_INSERT) begin
							if (not_full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (cnt_q != '0) begin
							issue_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (ctl.vld && ctl.last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					cnt_q   <= cnt_dec;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[AW-1:0];
		if (state_q == S_FIN) begin
			m_tuser_q <= STAT_OK;
			m_tdata_q <= {4'd0, (cnt_dec == '0), LIVE_W'(cnt_dec),
				best.duration, best.start, best.kind};
		end else if (s_acc && (in_op == OP_INSERT)) begin
			m_tuser_q <= not_full ? STAT_OK : STAT_FULL;
			m_tdata_q <= {4'd0, 1'b0, LIVE_W'(not_full ? cnt_q + CW'(1) : cnt_q),
				{(2 * TIME_W + KIND_W){1'b0}}};
		end else if (s_acc && (cnt_q == '0)) begin
			m_tuser_q <= STAT_EMPTY;
			m_tdata_q <= {4'd0, 1'b1, LIVE_W'(0), {(2 * TIME_W + KIND_W){1'b0}}};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("event count exceeds store depth");

	a_insert_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (in_op == OP_INSERT) && not_full) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("accepted insert did not bump the count");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CW'(rd_idx_s1) < cnt_q))
		else $error("scan read beyond the live entries");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (m_tvalid && (state_q == S_IDLE)))
		else $error("extract finished without a result");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while an extract is in progress");

endmodule
